FILE: src/apsp_pkg.sv
`default_nettype none

package apsp_pkg;

    localparam int VERTICES_DEFAULT = 16;
    localparam int DIST_W = 17;
    localparam int NODE_W = 4;
    localparam int OP_W = 2;

    // Distance value that marks a missing edge or an unreachable pair.
    localparam logic [DIST_W-1:0] NO_EDGE = DIST_W'(65536);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_RUN   = 2'd1,
        OP_QUERY = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] dest_node;
        logic [DIST_W-1:0] edge_weight;
    } cmd_t;

    typedef struct packed {
        logic [DIST_W-1:0] path_distance;
        logic [NODE_W-1:0] next_hop;
        logic              reachable;
        logic              done_flag;
    } result_t;

    // Write request to both tables; the address travels beside it.
    typedef struct packed {
        logic              we;
        logic [DIST_W-1:0] distance;
        logic [NODE_W-1:0] hop;
    } mem_wr_t;

    // Registered read data of the two table ports.
    typedef struct packed {
        logic [DIST_W-1:0] dist_a;
        logic [NODE_W-1:0] hop_a;
        logic [DIST_W-1:0] dist_b;
    } mem_rd_t;

endpackage

`default_nettype wire

FILE: src/apsp_mem.sv
`default_nettype none

module apsp_mem #(
    parameter int DEPTH = apsp_pkg::VERTICES_DEFAULT * apsp_pkg::VERTICES_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  apsp_pkg::mem_wr_t    wr,
    input  wire  [AW-1:0]        wr_addr,
    input  wire  [AW-1:0]        rd_a_addr,
    input  wire  [AW-1:0]        rd_b_addr,
    output apsp_pkg::mem_rd_t    rd
);

    logic [apsp_pkg::DIST_W-1:0] dist_mem [DEPTH];
    logic [apsp_pkg::NODE_W-1:0] hop_mem  [DEPTH];

    // One write port, two distance read ports, one hop read port on port A.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            dist_mem[wr_addr] <= wr.distance;
            hop_mem[wr_addr]  <= wr.hop;
        end
        rd.dist_a <= dist_mem[rd_a_addr];
        rd.hop_a  <= hop_mem[rd_a_addr];
        rd.dist_b <= dist_mem[rd_b_addr];
    end

    // Address beyond the table is never written.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |-> (int'(wr_addr) < DEPTH))
        else $error("table write beyond depth");

endmodule

`default_nettype wire

FILE: src/apsp_seq.sv
`default_nettype none

module apsp_seq #(
    parameter int VERTICES = apsp_pkg::VERTICES_DEFAULT,
    parameter int AW       = $clog2(VERTICES * VERTICES)
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                go,
    input  apsp_pkg::mem_rd_t  rd,
    output logic               busy,
    output logic               done,
    output logic [AW-1:0]      rd_a_addr,
    output logic [AW-1:0]      rd_b_addr,
    output apsp_pkg::mem_wr_t  wr,
    output logic [AW-1:0]      wr_addr
);

    localparam int NW = $clog2(VERTICES);
    localparam logic [NW-1:0] LAST_IDX = NW'(VERTICES - 1);
    localparam logic [AW-1:0] STRIDE = AW'(VERTICES);
    localparam logic [apsp_pkg::DIST_W:0] SUM_CAP = {1'b0, apsp_pkg::NO_EDGE};

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEG,
        S_CELL,
        S_FLUSH
    } state_t;

    state_t                       state_reg, state_next;
    logic [NW-1:0]                mid_reg, mid_next;
    logic [NW-1:0]                row_reg, row_next;
    logic [NW-1:0]                col_reg, col_next;
    logic                         cell_valid_reg, cell_valid_next;
    logic [AW-1:0]                cell_addr_reg, cell_addr_next;
    logic                         leg_cap_reg, leg_cap_next;
    logic [apsp_pkg::DIST_W-1:0]  leg_reg, leg_next;
    logic [apsp_pkg::NODE_W-1:0]  leg_hop_reg, leg_hop_next;
    logic                         done_reg, done_next;

    logic [AW-1:0]                cell_addr;
    logic [AW-1:0]                leg_addr;
    logic [apsp_pkg::DIST_W:0]    sum;
    logic                         better;

    assign cell_addr = AW'(row_reg) * STRIDE + AW'(col_reg);
    assign leg_addr  = AW'(row_reg) * STRIDE + AW'(mid_reg);
    assign rd_a_addr = (state_reg == S_LEG) ? leg_addr : cell_addr;
    assign rd_b_addr = AW'(mid_reg) * STRIDE + AW'(col_reg);

    // Relax the cell issued last cycle. Row mid and column mid never change
    // during pass mid, so reads and the trailing write never hit one entry.
    assign sum    = {1'b0, leg_reg} + {1'b0, rd.dist_b};
    assign better = (sum < SUM_CAP) && (sum < {1'b0, rd.dist_a});

    assign wr.we       = cell_valid_reg && better;
    assign wr.distance = sum[apsp_pkg::DIST_W-1:0];
    assign wr.hop      = leg_hop_reg;
    assign wr_addr     = cell_addr_reg;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    always_comb
    begin
        state_next      = state_reg;
        mid_next        = mid_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        cell_valid_next = (state_reg == S_CELL);
        cell_addr_next  = cell_addr;
        leg_cap_next    = (state_reg == S_LEG);
        leg_next        = leg_cap_reg ? rd.dist_a : leg_reg;
        leg_hop_next    = leg_cap_reg ? rd.hop_a : leg_hop_reg;
        done_next       = (state_reg == S_FLUSH);

        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    state_next = S_LEG;
                    mid_next   = '0;
                    row_next   = '0;
                    col_next   = '0;
                end
            end
            S_LEG:
            begin
                state_next = S_CELL;
            end
            S_CELL:
            begin
                col_next = col_reg + NW'(1);
                if (col_reg == LAST_IDX)
                begin
                    col_next   = '0;
                    state_next = S_LEG;
                    row_next   = row_reg + NW'(1);
                    if (row_reg == LAST_IDX)
                    begin
                        row_next = '0;
                        mid_next = mid_reg + NW'(1);
                        if (mid_reg == LAST_IDX)
                        begin
                            mid_next   = '0;
                            state_next = S_FLUSH;
                        end
                    end
                end
            end
            S_FLUSH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mid_reg        <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            cell_valid_reg <= 1'b0;
            cell_addr_reg  <= '0;
            leg_cap_reg    <= 1'b0;
            leg_reg        <= '0;
            leg_hop_reg    <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mid_reg        <= mid_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            cell_valid_reg <= cell_valid_next;
            cell_addr_reg  <= cell_addr_next;
            leg_cap_reg    <= leg_cap_next;
            leg_reg        <= leg_next;
            leg_hop_reg    <= leg_hop_next;
            done_reg       <= done_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid_reg |-> (state_reg != S_IDLE))
        else $error("relax write outside a run");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_FLUSH))
        else $error("run done without flush");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEG) |-> (col_reg == '0))
        else $error("leg fetch with column not at zero");

endmodule

`default_nettype wire

FILE: src/all_pairs_shortest_path_unit.sv
`default_nettype none

// Channel   Ports                     Transaction
// --------  ------------------------  -----------------------------------------
// command   start, busy, command      taken at a clock edge with start && !busy
// result    strobe, result            one cycle per strobe, receiver never stalls
//
// Load and query: one per cycle while not busy; busy stays low; the table read
// and the command kind are registered, then the result register strobes. A run
// holds busy through one leg fetch per row plus one cell per cycle on the
// two-read, one-write table port pair, then a flush state; its result is
// registered from the sequencer's done flag. Reset clears control only; the
// tables hold no valid state until loaded.

module all_pairs_shortest_path_unit #(
    parameter int VERTICES = apsp_pkg::VERTICES_DEFAULT
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  apsp_pkg::cmd_t     command,
    output logic               strobe,
    output apsp_pkg::result_t  result
);

    localparam int DEPTH = VERTICES * VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] STRIDE = AW'(VERTICES);

    logic                        accept;
    logic                        in_range;
    logic [AW-1:0]               cmd_addr;
    logic [apsp_pkg::DIST_W-1:0] load_weight;

    logic                        seq_busy;
    logic                        seq_done;
    logic [AW-1:0]               seq_a_addr;
    logic [AW-1:0]               seq_b_addr;
    apsp_pkg::mem_wr_t           seq_wr;
    logic [AW-1:0]               seq_wr_addr;

    apsp_pkg::mem_wr_t           mem_wr;
    logic [AW-1:0]               mem_wr_addr;
    logic [AW-1:0]               mem_a_addr;
    apsp_pkg::mem_rd_t           mem_rd;

    logic                        p1_valid_reg, p1_valid_next;
    logic [apsp_pkg::OP_W-1:0]   p1_op_reg, p1_op_next;
    logic                        p1_range_reg, p1_range_next;
    logic                        strobe_reg, strobe_next;
    apsp_pkg::result_t           result_reg, result_next;

    assign busy   = seq_busy;
    assign accept = start && !busy;

    assign in_range = (int'(command.source_node) < VERTICES) &&
                      (int'(command.dest_node) < VERTICES);
    assign cmd_addr = AW'(command.source_node) * STRIDE + AW'(command.dest_node);

    // Saturate oversized weights to the no-edge value.
    assign load_weight = (command.edge_weight > apsp_pkg::NO_EDGE) ?
                         apsp_pkg::NO_EDGE : command.edge_weight;

    // The sequencer owns the tables while busy; otherwise loads and queries do.
    always_comb
    begin
        if (seq_busy)
        begin
            mem_wr      = seq_wr;
            mem_wr_addr = seq_wr_addr;
            mem_a_addr  = seq_a_addr;
        end
        else
        begin
            mem_wr.we       = accept && (command.opcode == apsp_pkg::OP_LOAD) && in_range;
            mem_wr.distance = load_weight;
            mem_wr.hop      = command.dest_node;
            mem_wr_addr     = cmd_addr;
            mem_a_addr      = cmd_addr;
        end
    end

    apsp_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (mem_wr),
        .wr_addr   (mem_wr_addr),
        .rd_a_addr (mem_a_addr),
        .rd_b_addr (seq_b_addr),
        .rd        (mem_rd)
    );

    apsp_seq #(
        .VERTICES (VERTICES),
        .AW       (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (accept && (command.opcode == apsp_pkg::OP_RUN)),
        .rd        (mem_rd),
        .busy      (seq_busy),
        .done      (seq_done),
        .rd_a_addr (seq_a_addr),
        .rd_b_addr (seq_b_addr),
        .wr        (seq_wr),
        .wr_addr   (seq_wr_addr)
    );

    // Hold the command's kind for the cycle the table read returns.
    assign p1_valid_next = accept && (command.opcode != apsp_pkg::OP_RUN);
    assign p1_op_next    = command.opcode;
    assign p1_range_next = in_range;

    // Form the result transaction from the table read or the run completion.
    always_comb
    begin
        result_next = '0;
        strobe_next = p1_valid_reg || seq_done;
        if (p1_valid_reg)
        begin
            case (p1_op_reg)
                apsp_pkg::OP_QUERY:
                begin
                    if (p1_range_reg)
                    begin
                        result_next.path_distance = mem_rd.dist_a;
                        result_next.next_hop      = mem_rd.hop_a;
                        result_next.reachable     = (mem_rd.dist_a < apsp_pkg::NO_EDGE);
                    end
                    else
                    begin
                        result_next.path_distance = apsp_pkg::NO_EDGE;
                    end
                end
                default:
                begin
                    result_next = '0;
                end
            endcase
        end
        else if (seq_done)
        begin
            result_next.done_flag = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p1_op_reg    <= '0;
            p1_range_reg <= 1'b0;
            strobe_reg   <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            p1_valid_reg <= p1_valid_next;
            p1_op_reg    <= p1_op_next;
            p1_range_reg <= p1_range_next;
            strobe_reg   <= strobe_next;
            result_reg   <= result_next;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command.opcode == apsp_pkg::OP_RUN)) |=> busy)
        else $error("run accepted without going busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command.opcode != apsp_pkg::OP_RUN)) |=> ##1 strobe)
        else $error("load or query without result");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(p1_valid_reg && seq_done))
        else $error("table result collides with run completion");

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.done_flag) |-> $past(seq_done))
        else $error("done result without run completion");

endmodule

`default_nettype wire
